// File: src/fixed_point_alu_unit_defines.svh
// assertion macros for the fixed-point alu
`ifndef FIXED_POINT_ALU_UNIT_DEFINES_SVH
`define FIXED_POINT_ALU_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FPA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPA_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPA_ASSERT(label, clk, rst_n, prop, msg)
`define FPA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: src/fpa_pkg.sv
// shared types and constants for the fixed-point alu
package fpa_pkg;
	localparam int unsigned DataW = 32;
	localparam int unsigned ModeW = 3;
	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW = 2;

	typedef enum logic [ModeW-1:0] {
		MODE_ADD = 3'd0,
		MODE_SUB = 3'd1,
		MODE_MUL = 3'd2,
		MODE_DIV = 3'd3,
		MODE_CMP = 3'd4,
		MODE_INC = 3'd5,
		MODE_DEC = 3'd6,
		MODE_NOP = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		CLS_SIMPLE = 2'd0,
		CLS_MUL    = 2'd1,
		CLS_DIV    = 2'd2
	} op_class_t;

	// item as handed from the front part to the back part
	typedef struct packed {
		op_class_t         cls;
		logic              mul_or_div_zero;
		logic [DataW-1:0]  a;
		logic [DataW-1:0]  b;
		logic [DataW-1:0]  simple_res;
		logic              eq;
		logic              lt;
		logic              gt;
	} op_item_t;

	typedef struct packed {
		logic [DataW-1:0] value;
		logic             eq;
		logic             lt;
		logic             gt;
		logic             dz;
	} res_item_t;
endpackage

// File: src/fpa_front.sv
// front part: decodes items, does the simple operations and holds the input queue
module fpa_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [fpa_pkg::ModeW-1:0]   mode,
	input  logic [fpa_pkg::DataW-1:0]   operand_a,
	input  logic [fpa_pkg::DataW-1:0]   operand_b,
	input  logic                        push,
	output logic                        full,
	output fpa_pkg::op_item_t           q_item,
	output logic                        q_valid,
	input  logic                        q_pop
);
	import fpa_pkg::*;
	`include "fixed_point_alu_unit_defines.svh"

	op_item_t mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPtrW:0]   count_q;
	op_item_t cls_item;
	logic do_push, do_pop;

	always_comb begin
		cls_item = '0;
		cls_item.a = operand_a;
		cls_item.b = operand_b;
		cls_item.cls = CLS_SIMPLE;
		case (mode_t'(mode))
			MODE_ADD: cls_item.simple_res = operand_a + operand_b;
			MODE_SUB: cls_item.simple_res = operand_a - operand_b;
			MODE_INC: cls_item.simple_res = operand_a + DataW'(1);
			MODE_DEC: cls_item.simple_res = operand_a - DataW'(1);
			MODE_MUL: cls_item.cls = CLS_MUL;
			MODE_DIV: begin
				cls_item.cls = CLS_DIV;
				cls_item.mul_or_div_zero = (operand_b == '0);
			end
			MODE_CMP: begin
				cls_item.eq = (operand_a == operand_b);
				cls_item.lt = ($signed(operand_a) < $signed(operand_b));
				cls_item.gt = ($signed(operand_a) > $signed(operand_b));
			end
			default: cls_item.simple_res = '0;
		endcase
	end

	assign full = (count_q == (QPtrW+1)'(QDepth));
	assign do_push = push && !full;
	assign q_valid = (count_q != '0);
	assign do_pop = q_pop && q_valid;
	assign q_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cls_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			count_q <= count_q + (QPtrW+1)'(do_push) - (QPtrW+1)'(do_pop);
		end
	end

	`FPA_ASSERT(a_cnt_max, clk, arst_n, count_q <= (QPtrW+1)'(QDepth), "queue overfilled")
	`FPA_ASSERT(a_no_push_full, clk, arst_n, full |=> count_q == (QPtrW+1)'(QDepth) || $past(do_pop), "count moved while full")
	`FPA_ASSERT(a_ptr_gap, clk, arst_n, (wr_ptr_q - rd_ptr_q) == count_q[QPtrW-1:0], "pointer gap mismatch")
endmodule

// File: src/fpa_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
module fpa_divider #(
	parameter int unsigned FRAC_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [fpa_pkg::DataW-1:0] dividend,
	input  logic [fpa_pkg::DataW-1:0] divisor,
	output logic                      busy,
	output logic                      done,
	output logic [fpa_pkg::DataW-1:0] quotient
);
	import fpa_pkg::*;
	localparam int unsigned NumW = DataW + FRAC_BITS;
	localparam int unsigned CntW = $clog2(NumW + 1);

	logic [NumW-1:0]  num_q;
	logic [DataW:0]   rem_q;
	logic [DataW-1:0] den_q;
	logic             neg_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q, done_q;
	logic [DataW:0]   rem_sh, rem_sub;
	logic [DataW-1:0] abs_a, abs_b;
	logic [NumW-1:0]  q_fin;

	assign abs_a = dividend[DataW-1] ? -dividend : dividend;
	assign abs_b = divisor[DataW-1] ? -divisor : divisor;
	assign rem_sh = {rem_q[DataW-1:0], num_q[NumW-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign q_fin = neg_q ? -num_q : num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			num_q <= {abs_a, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			den_q <= abs_b;
			neg_q <= dividend[DataW-1] ^ divisor[DataW-1];
		end else if (busy_q) begin
			if (!rem_sub[DataW]) begin
				rem_q <= rem_sub;
				num_q <= {num_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				num_q <= {num_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = q_fin[DataW-1:0];
endmodule

// File: src/fpa_back.sv
// back part: multiply, divide and the result register
module fpa_back #(
	parameter int unsigned FRAC_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fpa_pkg::op_item_t q_item,
	input  logic              q_valid,
	output logic              q_pop,
	output fpa_pkg::res_item_t res,
	output logic              res_valid,
	input  logic              res_pop
);
	import fpa_pkg::*;
	`include "fixed_point_alu_unit_defines.svh"

	logic              valid_s1;
	op_item_t          item_s1;
	logic [2*DataW-1:0] prod_s1;
	logic              s1_free, s1_done, out_free;
	logic              div_start, div_busy, div_done;
	logic              div_ok_q;
	logic [DataW-1:0]  div_q;
	logic [2*DataW-1:0] prod_sh;
	logic signed [DataW-1:0]   mul_a, mul_b;
	logic signed [2*DataW-1:0] prod_full;
	res_item_t         res_q, s1_res;
	logic              res_valid_q;

	fpa_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(item_s1.a), .divisor(item_s1.b),
		.busy(div_busy), .done(div_done), .quotient(div_q)
	);

	assign out_free = !res_valid_q || res_pop;
	assign div_start = valid_s1 && item_s1.cls == CLS_DIV && !item_s1.mul_or_div_zero
		&& !div_busy && !div_done && !div_ok_q;
	// an item in stage 1 finishes at once unless it is a divide by nonzero, which waits for its result
	assign s1_done = valid_s1 && !(item_s1.cls == CLS_DIV && !item_s1.mul_or_div_zero
		&& !div_done && !div_ok_q);
	assign s1_free = !valid_s1 || (s1_done && out_free);
	assign q_pop = q_valid && s1_free;
	assign mul_a = q_item.a;
	assign mul_b = q_item.b;
	assign prod_full = mul_a * mul_b;
	assign prod_sh = $signed(prod_s1) >>> FRAC_BITS;

	always_comb begin
		s1_res = '0;
		s1_res.eq = item_s1.eq;
		s1_res.lt = item_s1.lt;
		s1_res.gt = item_s1.gt;
		case (item_s1.cls)
			CLS_MUL: s1_res.value = prod_sh[DataW-1:0];
			CLS_DIV: begin
				s1_res.dz = item_s1.mul_or_div_zero;
				s1_res.value = item_s1.mul_or_div_zero ? '0 : div_q;
			end
			default: s1_res.value = item_s1.simple_res;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_item;
			prod_s1 <= prod_full;
		end
		if (s1_done && out_free) res_q <= s1_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			div_ok_q <= 1'b0;
		end else begin
			if (s1_free) valid_s1 <= q_pop;
			if (out_free) res_valid_q <= s1_done;
			// keep a finished quotient while the result side stalls
			if (s1_free) div_ok_q <= 1'b0;
			else if (div_done) div_ok_q <= 1'b1;
		end
	end

	assign res = res_q;
	assign res_valid = res_valid_q;

	`FPA_ASSERT(a_div_in_s1, clk, arst_n, div_busy |-> valid_s1 && item_s1.cls == CLS_DIV, "divider busy without divide item")
	`FPA_ASSERT(a_done_once, clk, arst_n, div_done |=> !div_done, "divide done held")
	`FPA_ASSERT(a_hold_res, clk, arst_n, res_valid_q && !res_pop |=> res_valid_q && $stable(res_q), "result lost while stalled")
endmodule

// File: src/fixed_point_alu_unit.sv
// top level of the signed fixed-point alu
// Usage:
//   input queue: drive mode, operand_a, operand_b with push; an item is taken
//   at a clock edge with push high and full low.
//   result queue: while empty is low the oldest result sits on result_value
//   and the flags; it is taken at an edge with pop high.
//   add, sub, inc, dec, compare and multiply give one item per cycle unless
//   a divide or a low pop holds them; each passes the queue, stage 1 and the
//   result register. divide runs in a one-bit-per-cycle divider that takes
//   one item at a time, and items behind it wait in order.
//   a 4-entry queue between front and back lets the input side keep taking
//   items while the back part works or the receiver stalls.
//   when pop stays low the result register holds, the back part stops and the
//   queue fills until full rises.
//   reset (arst_n low) empties every queue and register at once; no item is
//   in flight after it.
module fixed_point_alu_unit #(
	parameter int unsigned FRAC_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [fpa_pkg::ModeW-1:0]  mode,
	input  logic signed [fpa_pkg::DataW-1:0] operand_a,
	input  logic signed [fpa_pkg::DataW-1:0] operand_b,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [fpa_pkg::DataW-1:0] result_value,
	output logic                       is_equal,
	output logic                       is_less,
	output logic                       is_greater,
	output logic                       divide_by_zero
);
	import fpa_pkg::*;

	op_item_t  q_item;
	logic      q_valid, q_pop, res_valid;
	res_item_t res;

	fpa_front u_front (
		.clk(clk), .arst_n(arst_n), .mode(mode), .operand_a(operand_a),
		.operand_b(operand_b), .push(push), .full(full),
		.q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
	);

	fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_item(q_item), .q_valid(q_valid),
		.q_pop(q_pop), .res(res), .res_valid(res_valid), .res_pop(pop)
	);

	assign empty = !res_valid;
	assign result_value = res.value;
	assign is_equal = res.eq;
	assign is_less = res.lt;
	assign is_greater = res.gt;
	assign divide_by_zero = res.dz;
endmodule
